// File: sv/button_debounce_click_counter_macros.svh
// ----------------------------------------------------------------------------
// button_debounce_click_counter assertion macros
// Clocked assertion helpers; empty bodies when synthesising
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_CLICK_COUNTER_MACROS_SVH
`define BUTTON_DEBOUNCE_CLICK_COUNTER_MACROS_SVH

`ifndef SYNTHESIS
`define BDCC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BDCC_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define BDCC_ASSERT(label, prop, msg)
`define BDCC_NEVER(label, expr, msg)
`endif

`endif

// File: sv/bdcc_pkg.sv
// ----------------------------------------------------------------------------
// bdcc_pkg
// Shared types and constants of the button debounce and click counter
// ----------------------------------------------------------------------------
package bdcc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int TIME_W     = 32;
    localparam int MS_W       = 16;
    localparam int CLICK_W    = 8;
    localparam int MODE_W     = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_CLICK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_MODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRESSED    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET     = 3'd4;

    // count modes
    localparam logic [MODE_W-1:0] MODE_PRESS   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BOTH    = 2'd2;

    // commands
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    localparam logic [MS_W-1:0] LONG_CLICK_RESET = 16'd350;
    localparam logic            RELEASED_LEVEL   = 1'b1;

    typedef struct packed {
        logic [MS_W-1:0]    debounce_ms;
        logic [MS_W-1:0]    long_click_ms;
        logic [MODE_W-1:0]  count_mode;
        logic               pressed_level;
        logic [CLICK_W-1:0] target_clicks;
    } cfg_t;

    typedef struct packed {
        logic              cmd;
        logic              raw_level;
        logic [TIME_W-1:0] now_ms;
    } item_t;

    typedef struct packed {
        logic              steady_level;
        logic              pressed_edge;
        logic              released_edge;
        logic              short_click;
        logic              seq_match;
        logic [TIME_W-1:0] edge_count;
    } result_t;

endpackage

// File: sv/button_debounce_click_counter.sv
// ----------------------------------------------------------------------------
// button_debounce_click_counter
// Timestamped button debouncer with edge counting and short-click runs
// ----------------------------------------------------------------------------
// Takes one transaction per clock cycle and returns one result transaction for
// each: the transaction is captured in an input register, the debounce, edge
// and click step runs in one pass of logic against the block state, and the
// answer lands in the result register. A stall on the output holds the result
// register and the input register; the input side stalls only while both are
// full. A clear transaction zeroes the edge count and leaves every other piece
// of state alone. Configuration registers are to be written through the write
// port while no transaction is in flight; the block itself does not enforce it.
`include "button_debounce_click_counter_macros.svh"

module button_debounce_click_counter
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [bdcc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bdcc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               cmd,
    input  logic                               raw_level,
    input  logic [bdcc_pkg::TIME_W-1:0]        now_ms,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               steady_level,
    output logic                               pressed_edge,
    output logic                               released_edge,
    output logic                               short_click,
    output logic                               seq_match,
    output logic [bdcc_pkg::TIME_W-1:0]        edge_count
);

    bdcc_pkg::cfg_t     cfg;
    bdcc_pkg::item_t    item_reg;
    bdcc_pkg::result_t  result;
    bdcc_pkg::result_t  result_reg;
    logic               item_valid_reg;
    logic               out_valid_reg;
    logic               advance;
    logic               in_take;

    assign advance  = item_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = item_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    bdcc_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bdcc_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .step_en (advance),
        .item    (item_reg),
        .result  (result)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.cmd       <= cmd;
            item_reg.raw_level <= raw_level;
            item_reg.now_ms    <= now_ms;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign steady_level  = result_reg.steady_level;
    assign pressed_edge  = result_reg.pressed_edge;
    assign released_edge = result_reg.released_edge;
    assign short_click   = result_reg.short_click;
    assign seq_match     = result_reg.seq_match;
    assign edge_count    = result_reg.edge_count;

    `BDCC_NEVER(a_one_edge_kind, out_valid_reg && pressed_edge && released_edge, "both edges in one transaction")
    `BDCC_ASSERT(a_click_on_release, (out_valid_reg && short_click) |-> released_edge, "short click without release")
    `BDCC_ASSERT(a_clear_zeroes, (advance && item_reg.cmd == bdcc_pkg::CMD_CLEAR) |=> (edge_count == '0), "clear left edge count")
    `BDCC_ASSERT(a_step_lands, advance |=> out_valid_reg, "stepped transaction lost")

endmodule

// File: sv/bdcc_cfg_regs.sv
// ----------------------------------------------------------------------------
// bdcc_cfg_regs
// Configuration register file written through the plain write port
// ----------------------------------------------------------------------------
module bdcc_cfg_regs
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [bdcc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bdcc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output bdcc_pkg::cfg_t                     cfg
);

    bdcc_pkg::cfg_t cfg_reg;
    bdcc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                bdcc_pkg::REG_DEBOUNCE:
                    cfg_next.debounce_ms = cfg_wdata;
                bdcc_pkg::REG_LONG_CLICK:
                    cfg_next.long_click_ms = cfg_wdata;
                bdcc_pkg::REG_COUNT_MODE:
                    cfg_next.count_mode = cfg_wdata[bdcc_pkg::MODE_W-1:0];
                bdcc_pkg::REG_PRESSED:
                    cfg_next.pressed_level = cfg_wdata[0];
                bdcc_pkg::REG_TARGET:
                    cfg_next.target_clicks = cfg_wdata[bdcc_pkg::CLICK_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms   <= '0;
            cfg_reg.long_click_ms <= bdcc_pkg::LONG_CLICK_RESET;
            cfg_reg.count_mode    <= bdcc_pkg::MODE_PRESS;
            cfg_reg.pressed_level <= 1'b0;
            cfg_reg.target_clicks <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: sv/bdcc_core.sv
// ----------------------------------------------------------------------------
// bdcc_core
// Debounce, edge counting and click run state with its single-step update
// ----------------------------------------------------------------------------
module bdcc_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  bdcc_pkg::cfg_t      cfg,
    input  logic                step_en,
    input  bdcc_pkg::item_t     item,
    output bdcc_pkg::result_t   result
);

    logic                             raw_last_reg,     raw_last_next;
    logic                             steady_prev_reg,  steady_prev_next;
    logic                             steady_now_reg,   steady_now_next;
    logic [bdcc_pkg::TIME_W-1:0]      change_time_reg,  change_time_next;
    logic [bdcc_pkg::TIME_W-1:0]      press_time_reg,   press_time_next;
    logic [bdcc_pkg::TIME_W-1:0]      edge_counter_reg, edge_counter_next;
    logic [bdcc_pkg::CLICK_W-1:0]     click_run_reg,    click_run_next;
    logic                             pending_reg,      pending_next;

    logic [bdcc_pkg::TIME_W-1:0]      held_ms;
    logic [bdcc_pkg::TIME_W-1:0]      since_press_ms;
    logic [bdcc_pkg::CLICK_W-1:0]     run_added;
    logic                             shift;
    logic                             steady_change;
    logic                             pe;
    logic                             re;
    logic                             sc;
    logic                             count_it;
    logic                             idle;

    always_comb
    begin
        raw_last_next     = raw_last_reg;
        steady_prev_next  = steady_prev_reg;
        steady_now_next   = steady_now_reg;
        change_time_next  = change_time_reg;
        press_time_next   = press_time_reg;
        edge_counter_next = edge_counter_reg;
        click_run_next    = click_run_reg;
        pending_next      = pending_reg;
        pe                = 1'b0;
        re                = 1'b0;
        sc                = 1'b0;
        idle              = 1'b0;
        count_it          = 1'b0;
        shift             = 1'b0;
        steady_change     = 1'b0;
        run_added         = click_run_reg;

        if (item.raw_level != raw_last_reg)
        begin
            change_time_next = item.now_ms;
        end
        held_ms        = item.now_ms - change_time_next;
        since_press_ms = item.now_ms - press_time_reg;

        if (item.cmd == bdcc_pkg::CMD_CLEAR)
        begin
            change_time_next  = change_time_reg;
            edge_counter_next = '0;
        end
        else
        begin
            raw_last_next = item.raw_level;
            shift = held_ms >= {{(bdcc_pkg::TIME_W-bdcc_pkg::MS_W){1'b0}}, cfg.debounce_ms};
            if (shift)
            begin
                steady_prev_next = steady_now_reg;
                steady_now_next  = item.raw_level;
            end
            steady_change = shift && (steady_now_reg != item.raw_level);
            pe = steady_change && (item.raw_level == cfg.pressed_level);
            re = steady_change && !pe;
            unique case (cfg.count_mode)
                bdcc_pkg::MODE_PRESS:   count_it = pe;
                bdcc_pkg::MODE_RELEASE: count_it = re;
                bdcc_pkg::MODE_BOTH:    count_it = steady_change;
                default:                count_it = 1'b0;
            endcase
            if (count_it)
            begin
                edge_counter_next = edge_counter_reg + 1'b1;
            end
            if (pe)
            begin
                press_time_next = change_time_next;
            end
            sc = re && (since_press_ms <
                 {{(bdcc_pkg::TIME_W-bdcc_pkg::MS_W){1'b0}}, cfg.long_click_ms});
            if (sc)
            begin
                run_added = click_run_reg + 1'b1;
            end
            click_run_next = pending_reg ? '0 : run_added;
            idle = held_ms >= {{(bdcc_pkg::TIME_W-bdcc_pkg::MS_W){1'b0}}, cfg.long_click_ms};
            pending_next = idle;
        end
    end

    always_comb
    begin
        result.steady_level  = steady_now_next;
        result.pressed_edge  = pe;
        result.released_edge = re;
        result.short_click   = sc;
        result.seq_match     = idle && (click_run_next == cfg.target_clicks);
        result.edge_count    = edge_counter_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_last_reg     <= bdcc_pkg::RELEASED_LEVEL;
            steady_prev_reg  <= bdcc_pkg::RELEASED_LEVEL;
            steady_now_reg   <= bdcc_pkg::RELEASED_LEVEL;
            change_time_reg  <= '0;
            press_time_reg   <= '0;
            edge_counter_reg <= '0;
            click_run_reg    <= '0;
            pending_reg      <= 1'b0;
        end
        else if (step_en)
        begin
            raw_last_reg     <= raw_last_next;
            steady_prev_reg  <= steady_prev_next;
            steady_now_reg   <= steady_now_next;
            change_time_reg  <= change_time_next;
            press_time_reg   <= press_time_next;
            edge_counter_reg <= edge_counter_next;
            click_run_reg    <= click_run_next;
            pending_reg      <= pending_next;
        end
    end

endmodule

// File: tb/button_debounce_click_counter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_click_counter_test
// Self-checking bench for the timestamped button debouncer: directed tests
// cover the reset configuration, timestamp wrap, the clear command, flicker
// after a steady change, a click lost to the run clear and the unused count
// mode. A long receiver hold-off fills the pipeline, and random click runs
// follow under changing register settings. Every result transaction is
// checked field by field against an in-bench prediction of the block.
// ----------------------------------------------------------------------------
module button_debounce_click_counter_test;

    localparam int CFG_IDX_W  = bdcc_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = bdcc_pkg::CFG_DATA_W;
    localparam int TIME_W     = bdcc_pkg::TIME_W;
    localparam int MS_W       = bdcc_pkg::MS_W;
    localparam int CLICK_W    = bdcc_pkg::CLICK_W;
    localparam int MODE_W     = bdcc_pkg::MODE_W;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int ITEM_GOAL      = 800;
    localparam int PHASE_ITEMS    = 100;
    localparam int PRESSURE_HOLD  = 120;
    localparam int PRESSURE_ITEMS = 40;
    localparam int DRAIN_CYCLES   = 6;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_valid  = 1'b0;
    logic                  cmd       = bdcc_pkg::CMD_SAMPLE;
    logic                  raw_level = bdcc_pkg::RELEASED_LEVEL;
    logic [TIME_W-1:0]     now_ms    = '0;
    logic                  out_stall = 1'b0;
    logic                  in_stall;
    logic                  out_valid;
    logic                  steady_level;
    logic                  pressed_edge;
    logic                  released_edge;
    logic                  short_click;
    logic                  seq_match;
    logic [TIME_W-1:0]     edge_count;

    // predicted block state and register copy
    bdcc_pkg::cfg_t        model_cfg;
    logic                  raw_last;
    logic                  steady_prev;
    logic                  steady_now;
    logic [TIME_W-1:0]     change_time;
    logic [TIME_W-1:0]     press_time;
    logic [TIME_W-1:0]     edge_counter;
    logic [CLICK_W-1:0]    click_run;
    logic                  run_clear_pending;

    bdcc_pkg::result_t     expected_results[$];
    logic [TIME_W-1:0]     clock_ms;
    int unsigned           items_sent    = 0;
    int unsigned           error_count   = 0;
    int                    hold_remaining = 0;
    bit                    sender_gaps   = 1'b1;
    bit                    receiver_gaps = 1'b1;

    button_debounce_click_counter u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .raw_level     (raw_level),
        .now_ms        (now_ms),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .steady_level  (steady_level),
        .pressed_edge  (pressed_edge),
        .released_edge (released_edge),
        .short_click   (short_click),
        .seq_match     (seq_match),
        .edge_count    (edge_count)
    );

    initial
    begin
        forever
        begin
            #2 clk = ~clk;
        end
    end

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic bdcc_pkg::result_t debounce_predict(input bdcc_pkg::item_t it);
        bdcc_pkg::result_t res;
        logic              shifted;
        logic [TIME_W-1:0] since_change;
        logic [TIME_W-1:0] since_press;
        res     = '0;
        shifted = 1'b0;
        if (it.cmd == bdcc_pkg::CMD_CLEAR)
        begin
            edge_counter = '0;
        end
        else
        begin
            if (it.raw_level != raw_last)
            begin
                change_time = it.now_ms;
                raw_last    = it.raw_level;
            end
            since_change = it.now_ms - change_time;
            if (since_change >= {16'd0, model_cfg.debounce_ms})
            begin
                steady_prev = steady_now;
                steady_now  = it.raw_level;
                shifted     = 1'b1;
            end
            if (shifted && steady_prev != steady_now)
            begin
                res.pressed_edge  = (steady_now == model_cfg.pressed_level);
                res.released_edge = !res.pressed_edge;
                if (model_cfg.count_mode == bdcc_pkg::MODE_BOTH
                    || (model_cfg.count_mode == bdcc_pkg::MODE_PRESS
                        && res.pressed_edge)
                    || (model_cfg.count_mode == bdcc_pkg::MODE_RELEASE
                        && res.released_edge))
                    edge_counter = edge_counter + 1'b1;
                if (res.pressed_edge)
                    press_time = change_time;
                since_press = it.now_ms - press_time;
                if (res.released_edge && since_press < {16'd0, model_cfg.long_click_ms})
                begin
                    res.short_click = 1'b1;
                    click_run       = click_run + 1'b1;
                end
            end
            if (run_clear_pending)
            begin
                click_run         = '0;
                run_clear_pending = 1'b0;
            end
            if (since_change >= {16'd0, model_cfg.long_click_ms})
            begin
                run_clear_pending = 1'b1;
                res.seq_match     = (click_run == model_cfg.target_clicks);
            end
        end
        res.steady_level = steady_now;
        res.edge_count   = edge_counter;
        return res;
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        $display("ERROR %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [TIME_W-1:0] got,
                               input logic [TIME_W-1:0] want);
        if (got !== want)
            report_error($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // result checker
    always @(posedge clk)
    begin : check_results
        bdcc_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                report_error("result transaction with nothing expected");
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("steady_level", TIME_W'(steady_level),
                            TIME_W'(want.steady_level));
                check_field("pressed_edge", TIME_W'(pressed_edge),
                            TIME_W'(want.pressed_edge));
                check_field("released_edge", TIME_W'(released_edge),
                            TIME_W'(want.released_edge));
                check_field("short_click", TIME_W'(short_click),
                            TIME_W'(want.short_click));
                check_field("seq_match", TIME_W'(seq_match), TIME_W'(want.seq_match));
                check_field("edge_count", edge_count, want.edge_count);
            end
        end
    end

    // receiver side: hold-off count, random stalls
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_remaining > 0)
            begin
                out_stall <= 1'b1;
                hold_remaining--;
            end
            else
            begin
                out_stall <= receiver_gaps && ($urandom_range(0, 99) < 8);
            end
        end
    end

    // entered and left at a falling edge; valid stays high for a following call
    task automatic send_item(input logic c, input logic r, input logic [TIME_W-1:0] t);
        bdcc_pkg::item_t it;
        while (sender_gaps && $urandom_range(0, 99) < 8)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= c;
        raw_level <= r;
        now_ms    <= t;
        do
            @(posedge clk);
        while (in_stall);
        it.cmd       = c;
        it.raw_level = r;
        it.now_ms    = t;
        expected_results.push_back(debounce_predict(it));
        items_sent++;
        @(negedge clk);
    endtask

    task automatic sample(input logic level, input logic [TIME_W-1:0] dt);
        clock_ms = clock_ms + dt;
        send_item(bdcc_pkg::CMD_SAMPLE, level, clock_ms);
    endtask

    task automatic clear_count();
        send_item(bdcc_pkg::CMD_CLEAR, 1'($urandom_range(0, 1)), $urandom);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
        case (idx)
            bdcc_pkg::REG_DEBOUNCE:   model_cfg.debounce_ms   = data;
            bdcc_pkg::REG_LONG_CLICK: model_cfg.long_click_ms = data;
            bdcc_pkg::REG_COUNT_MODE: model_cfg.count_mode    = data[MODE_W-1:0];
            bdcc_pkg::REG_PRESSED:    model_cfg.pressed_level = data[0];
            bdcc_pkg::REG_TARGET:     model_cfg.target_clicks = data[CLICK_W-1:0];
            default: ;
        endcase
    endtask

    // junk sets the unused upper bits of the narrow registers
    task automatic set_config(input logic [MS_W-1:0] deb, input logic [MS_W-1:0] lng,
                              input logic [MODE_W-1:0] mode, input logic pressed,
                              input logic [CLICK_W-1:0] target, input bit junk);
        logic [CFG_DATA_W-1:0] fill;
        fill = junk ? CFG_DATA_W'($urandom) : '0;
        write_reg(bdcc_pkg::REG_DEBOUNCE, deb);
        write_reg(bdcc_pkg::REG_LONG_CLICK, lng);
        write_reg(bdcc_pkg::REG_COUNT_MODE, {fill[CFG_DATA_W-1:MODE_W], mode});
        write_reg(bdcc_pkg::REG_PRESSED, {fill[CFG_DATA_W-1:1], pressed});
        write_reg(bdcc_pkg::REG_TARGET, {fill[CFG_DATA_W-1:CLICK_W], target});
    endtask

    task automatic hold_level(input logic level, input logic [TIME_W-1:0] dur);
        logic [TIME_W-1:0] spent;
        logic [TIME_W-1:0] dt;
        spent = '0;
        do
        begin
            dt = $urandom_range(1, dur / 3 + 1);
            sample(level, dt);
            spent = spent + dt;
        end
        while (spent < dur);
    endtask

    task automatic bounce(input logic level);
        logic [TIME_W-1:0] span;
        span = model_cfg.debounce_ms / 2 + 1;
        sample(level, $urandom_range(0, span));
        repeat ($urandom_range(0, 2))
        begin
            sample(!level, $urandom_range(0, span));
            sample(level, $urandom_range(0, span));
        end
    endtask

    task automatic click();
        logic              pressed;
        logic [TIME_W-1:0] hold;
        pressed = model_cfg.pressed_level;
        hold    = $urandom_range(0, model_cfg.long_click_ms
                                    + model_cfg.long_click_ms / 4 + 5);
        bounce(pressed);
        hold_level(pressed, model_cfg.debounce_ms + hold);
        bounce(!pressed);
        hold_level(!pressed, model_cfg.debounce_ms
                             + $urandom_range(1, model_cfg.long_click_ms / 4 + 1));
    endtask

    task automatic test_defaults_and_wrap();
        clock_ms = '0;
        sample(1'b1, 0);
        sample(1'b0, 10);
        sample(1'b1, 90);
        sample(1'b1, 400);
        sample(1'b1, 10);
        clear_count();
        clock_ms = 32'hFFFF_FFF0;
        sample(1'b0, 0);
        sample(1'b1, 32'h20);
        sample(1'b1, 32'hFFFF_FFEF);
        drain();
    endtask

    task automatic test_edge_timing();
        set_config(16'd20, 16'd350, bdcc_pkg::MODE_BOTH, 1'b1, 8'd1, 1'b0);
        clock_ms = 32'd1000;
        sample(1'b0, 0);
        sample(1'b0, 20);
        sample(1'b1, 5);
        sample(1'b1, 20);
        // flicker after the press holds the timer
        sample(1'b0, 3);
        sample(1'b1, 1);
        sample(1'b1, 10);
        sample(1'b1, 20);
        drain();
    endtask

    task automatic test_lost_click();
        set_config(16'd0, 16'd350, bdcc_pkg::MODE_BOTH, 1'b0, 8'd0, 1'b0);
        clock_ms = 32'd2000;
        sample(1'b1, 0);
        sample(1'b0, 10);
        sample(1'b0, 390);
        // time steps back so the release is short while the run clear is due
        clock_ms = 32'd2100;
        sample(1'b1, 0);
        sample(1'b1, 400);
        drain();
    endtask

    task automatic test_unused_mode();
        set_config(16'd0, 16'd350, MODE_UNUSED, 1'b0, 8'd0, 1'b1);
        sample(1'b0, 5);
        sample(1'b1, 5);
        sample(1'b0, 5);
        drain();
    endtask

    task automatic test_pressure();
        set_config(16'd3, 16'd100, bdcc_pkg::MODE_BOTH, 1'b0, 8'd2, 1'b0);
        sender_gaps    = 1'b0;
        hold_remaining = PRESSURE_HOLD;
        repeat (PRESSURE_ITEMS)
            sample(1'($urandom_range(0, 1)), $urandom_range(0, 40));
        sender_gaps = 1'b1;
        drain();
    endtask

    task automatic test_random_traffic();
        int unsigned       phase;
        int unsigned       phase_end;
        int unsigned       pick;
        logic [MS_W-1:0]   deb;
        logic [MS_W-1:0]   lng;
        logic [CLICK_W-1:0] target;
        phase = 0;
        while (items_sent < ITEM_GOAL)
        begin
            pick   = $urandom_range(0, 99);
            deb    = (pick < 25) ? 16'd0
                   : (pick < 90) ? MS_W'($urandom_range(1, 25)) : 16'hFFFF;
            pick   = $urandom_range(0, 99);
            lng    = (pick < 10) ? 16'd0 : (pick < 20) ? 16'hFFFF
                                              : MS_W'($urandom_range(30, 300));
            target = ($urandom_range(0, 9) == 0) ? 8'hFF : CLICK_W'($urandom_range(0, 3));
            if (phase == 0)
                set_config(16'hFFFF, 16'hFFFF, bdcc_pkg::MODE_BOTH, 1'b1, 8'hFF, 1'b1);
            else if (phase == 1)
                set_config(16'd0, 16'd0, bdcc_pkg::MODE_PRESS, 1'b0, 8'd0, 1'b0);
            else
                set_config(deb, lng, MODE_W'($urandom_range(0, 3)),
                           1'($urandom_range(0, 1)), target, 1'($urandom_range(0, 1)));
            // one phase runs with no idling on either side
            sender_gaps   = (phase != 2);
            receiver_gaps = (phase != 2);
            phase_end     = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 75)
                begin
                    repeat ($urandom_range(0, 4))
                        click();
                    hold_level(!model_cfg.pressed_level,
                               model_cfg.long_click_ms + $urandom_range(1, 30));
                end
                else if (pick < 90)
                begin
                    clock_ms = $urandom;
                    send_item($urandom_range(0, 9) == 0, 1'($urandom_range(0, 1)),
                              clock_ms);
                end
                else
                begin
                    clear_count();
                end
            end
            drain();
            phase++;
        end
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
    endtask

    initial
    begin
        model_cfg.debounce_ms   = '0;
        model_cfg.long_click_ms = bdcc_pkg::LONG_CLICK_RESET;
        model_cfg.count_mode    = bdcc_pkg::MODE_PRESS;
        model_cfg.pressed_level = 1'b0;
        model_cfg.target_clicks = '0;
        raw_last          = bdcc_pkg::RELEASED_LEVEL;
        steady_prev       = bdcc_pkg::RELEASED_LEVEL;
        steady_now        = bdcc_pkg::RELEASED_LEVEL;
        change_time       = '0;
        press_time        = '0;
        edge_counter      = '0;
        click_run         = '0;
        run_clear_pending = 1'b0;
        clock_ms          = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_defaults_and_wrap();
        test_edge_timing();
        test_lost_click();
        test_unused_mode();
        test_pressure();
        test_random_traffic();

        drain();
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: button_debounce_click_counter.f
+incdir+sv
sv/bdcc_pkg.sv
sv/bdcc_cfg_regs.sv
sv/bdcc_core.sv
sv/button_debounce_click_counter.sv
tb/button_debounce_click_counter_test.sv
